[src/dbc_pkg.sv]
// Shared types, sizes and codes for the debounced input event counter.
`timescale 1ns / 1ps

package dbc_pkg;

   localparam int CHANNELS   = 4;
   localparam int COUNTERS   = 4;
   localparam int PINS       = 8;
   localparam int SETUP_REGS = 4;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;
   localparam int SETUP_W    = 44;

   // Counter actions as held in the setup registers.
   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_INC     = 3'd1;
   localparam logic [2:0] ACT_DEC     = 3'd2;
   localparam logic [2:0] ACT_SET     = 3'd3;
   localparam logic [2:0] ACT_INC_SEC = 3'd4;
   localparam logic [2:0] ACT_DEC_SEC = 3'd5;
   localparam logic [2:0] ACT_QUAD    = 3'd6;

   // Resolved counter operations passed from a channel to the counter bank.
   localparam logic [1:0] OP_INC = 2'd0;
   localparam logic [1:0] OP_DEC = 2'd1;
   localparam logic [1:0] OP_SET = 2'd2;

   typedef struct packed {
      logic [15:0] fall_dly;
      logic [15:0] rise_dly;
      logic [1:0]  cidx;
      logic [2:0]  fall_act;
      logic [2:0]  rise_act;
      logic        sec;
      logic [2:0]  pin;
   } setup_type;

   typedef struct packed {
      logic       hit;
      logic [1:0] cidx;
      logic [1:0] op;
   } event_type;

   // Pins at or beyond the pin count read as low.
   function automatic logic pin_bit(input logic [7:0] pins, input logic [3:0] idx);
      logic result;
      result = 1'b0;
      if (int'(idx) < PINS && idx < 4'd8) begin
         result = pins[idx[2:0]];
      end
      return result;
   endfunction

endpackage

[src/dbc_csr.sv]
// Configuration register file holding one setup word per channel.
`timescale 1ns / 1ps

module dbc_csr (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [dbc_pkg::CSR_ADDR_W-1:0]          csr_paddr,
   input  logic [dbc_pkg::CSR_DATA_W-1:0]          csr_pwdata,
   output logic [dbc_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                    csr_pready,
   output dbc_pkg::setup_type [dbc_pkg::CHANNELS-1:0] setups
);

   dbc_pkg::setup_type [dbc_pkg::CHANNELS-1:0] setup_ff;
   logic [1:0] reg_index;
   logic       write_en;

   assign reg_index  = csr_paddr[dbc_pkg::CSR_ADDR_W-1:3];
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign setups     = setup_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_ff <= '0;
      end else if (write_en) begin
         for (int i = 0; i < dbc_pkg::CHANNELS; i++) begin
            if (i < dbc_pkg::SETUP_REGS && int'(reg_index) == i) begin
               setup_ff[i] <= csr_pwdata[dbc_pkg::SETUP_W-1:0];
            end
         end
      end
   end

   always_comb begin
      csr_prdata = '0;
      for (int i = 0; i < dbc_pkg::CHANNELS; i++) begin
         if (i < dbc_pkg::SETUP_REGS && int'(reg_index) == i) begin
            csr_prdata = {{(dbc_pkg::CSR_DATA_W-dbc_pkg::SETUP_W){1'b0}}, setup_ff[i]};
         end
      end
   end

endmodule

[src/dbc_channel.sv]
// Debounce state and action decode for one input channel.
`timescale 1ns / 1ps

module dbc_channel (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  dbc_pkg::setup_type setup,
   input  logic [7:0]         pins,
   input  logic [7:0]         diff,
   output dbc_pkg::event_type event_out
);

   logic [1:0]  settled_ff, settled_in;
   logic [15:0] remain_ff, remain_in;
   logic        armed_ff, armed_in;

   logic [3:0]  sec_idx;
   logic        detected;
   logic [15:0] remain_cur;
   logic        armed_cur;
   logic        expire;
   logic [1:0]  now_level;
   logic [2:0]  act;
   logic        act_hit;
   logic [1:0]  act_op;

   assign sec_idx  = {1'b0, setup.pin} + 4'd1;
   assign detected = dbc_pkg::pin_bit(diff, {1'b0, setup.pin})
                     || (setup.sec && dbc_pkg::pin_bit(diff, sec_idx));

   // A change reloads the countdown from the delay for the settled direction.
   assign remain_cur = detected ? (settled_ff[0] ? setup.fall_dly : setup.rise_dly)
                                : remain_ff;
   assign armed_cur  = detected || armed_ff;
   assign expire     = armed_cur && (remain_cur == 16'd0);

   assign now_level = {setup.sec && dbc_pkg::pin_bit(pins, sec_idx),
                       dbc_pkg::pin_bit(pins, {1'b0, setup.pin})};
   assign act       = now_level[0] ? setup.rise_act : setup.fall_act;

   always_comb begin
      act_hit = 1'b0;
      act_op  = dbc_pkg::OP_INC;
      case (act)
         dbc_pkg::ACT_INC: begin
            act_hit = 1'b1;
         end
         dbc_pkg::ACT_DEC: begin
            act_hit = 1'b1;
            act_op  = dbc_pkg::OP_DEC;
         end
         dbc_pkg::ACT_SET: begin
            act_hit = 1'b1;
            act_op  = dbc_pkg::OP_SET;
         end
         dbc_pkg::ACT_INC_SEC: begin
            act_hit = now_level[1];
         end
         dbc_pkg::ACT_DEC_SEC: begin
            act_hit = now_level[1];
            act_op  = dbc_pkg::OP_DEC;
         end
         dbc_pkg::ACT_QUAD: begin
            act_hit = 1'b1;
            act_op  = now_level[1] ? dbc_pkg::OP_INC : dbc_pkg::OP_DEC;
         end
         default: begin
            act_hit = 1'b0;
         end
      endcase
   end

   assign event_out.hit  = advance && expire && (now_level[0] != settled_ff[0])
                           && (int'(setup.cidx) < dbc_pkg::COUNTERS) && act_hit;
   assign event_out.cidx = setup.cidx;
   assign event_out.op   = act_op;

   always_comb begin
      settled_in = settled_ff;
      remain_in  = remain_cur;
      armed_in   = armed_cur;
      if (armed_cur) begin
         if (remain_cur != 16'd0) begin
            remain_in = remain_cur - 16'd1;
         end else begin
            settled_in = now_level;
            armed_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settled_ff <= '0;
         remain_ff  <= '0;
         armed_ff   <= 1'b0;
      end else if (advance) begin
         settled_ff <= settled_in;
         remain_ff  <= remain_in;
         armed_ff   <= armed_in;
      end
   end

endmodule

[src/dbc_counters.sv]
// Counter bank that applies channel events in channel order, plus the sequence number.
`timescale 1ns / 1ps

module dbc_counters (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       advance,
   input  dbc_pkg::event_type [dbc_pkg::CHANNELS-1:0] events,
   output logic [dbc_pkg::COUNTERS-1:0][7:0]          counters,
   output logic [7:0]                                 sequence_number,
   output logic                                       changed
);

   logic [dbc_pkg::COUNTERS-1:0][7:0] count_ff, count_in;
   logic [7:0] seq_ff, seq_in;
   logic       changed_ff, changed_in;

   // Each counter sees the channels in index order, so two channels aimed at
   // the same counter on one tick both take effect.
   always_comb begin
      count_in   = count_ff;
      changed_in = 1'b0;
      for (int i = 0; i < dbc_pkg::CHANNELS; i++) begin
         if (events[i].hit) begin
            changed_in = 1'b1;
         end
      end
      for (int k = 0; k < dbc_pkg::COUNTERS; k++) begin
         for (int i = 0; i < dbc_pkg::CHANNELS; i++) begin
            if (events[i].hit && int'(events[i].cidx) == k) begin
               case (events[i].op)
                  dbc_pkg::OP_INC: count_in[k] = count_in[k] + 8'd1;
                  dbc_pkg::OP_DEC: count_in[k] = count_in[k] - 8'd1;
                  dbc_pkg::OP_SET: count_in[k] = count_in[k] | 8'd1;
                  default:         count_in[k] = count_in[k];
               endcase
            end
         end
      end
      seq_in = seq_ff + {7'd0, changed_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         seq_ff     <= '0;
         changed_ff <= 1'b0;
      end else if (advance) begin
         count_ff   <= count_in;
         seq_ff     <= seq_in;
         changed_ff <= changed_in;
      end
   end

   assign counters        = count_ff;
   assign sequence_number = seq_ff;
   assign changed         = changed_ff;

endmodule

[src/debounced_input_event_counter_core.sv]
// Top level of the debounced input event counter: request stage, channels and counters.
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_pin_levels (8 bits)
// rsp       out        rsp_valid/rsp_ready    counters a..d, sequence number, changed flag
// csr       in/out     APB, pready always 1   64-bit setup word per channel at 8*i
//
// One request per clock while responses are taken: a request enters the input
// stage, and from there all channels and the counter bank settle it in a single
// pass into the result register, which presents the response.
// The longest path of that single pass chains up to four channel actions on one
// counter through short 8-bit adders.
// Reset is synchronous and clears all debounce state, counters, the sequence
// number and the setup registers; no clearing pass is needed.
// A stalled response holds the input stage, which still takes one more request
// and then drops req_ready until the response is taken.

module debounced_input_event_counter_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_pin_levels,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_counter_a,
   output logic [7:0]                     rsp_counter_b,
   output logic [7:0]                     rsp_counter_c,
   output logic [7:0]                     rsp_counter_d,
   output logic [7:0]                     rsp_sequence_number,
   output logic                           rsp_changed,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [dbc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [dbc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [dbc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   dbc_pkg::setup_type [dbc_pkg::CHANNELS-1:0] setups;
   dbc_pkg::event_type [dbc_pkg::CHANNELS-1:0] events;
   logic [dbc_pkg::COUNTERS-1:0][7:0]          counters;

   logic       stage_valid_ff;
   logic [7:0] stage_pins_ff;
   logic [7:0] prev_pins_ff;
   logic       rsp_valid_ff;
   logic       advance;
   logic [7:0] diff;

   // The staged request moves on whenever the result register is free or
   // being emptied in this cycle.
   assign advance   = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;

   // Changes are measured against the previous request's pins, which start at
   // zero after reset so pins high on the first request count as changes.
   assign diff = stage_pins_ff ^ prev_pins_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         prev_pins_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            stage_valid_ff <= 1'b1;
         end else if (advance) begin
            stage_valid_ff <= 1'b0;
         end
         if (advance) begin
            prev_pins_ff <= stage_pins_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_pins_ff <= req_pin_levels;
      end
   end

   dbc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .setups      (setups)
   );

   for (genvar g = 0; g < dbc_pkg::CHANNELS; g++) begin : g_channel
      dbc_channel u_channel (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .setup     (setups[g]),
         .pins      (stage_pins_ff),
         .diff      (diff),
         .event_out (events[g])
      );
   end

   dbc_counters u_counters (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .events          (events),
      .counters        (counters),
      .sequence_number (rsp_sequence_number),
      .changed         (rsp_changed)
   );

   // Counters beyond the configured count read as zero.
   if (dbc_pkg::COUNTERS > 0) begin : g_cnt_a
      assign rsp_counter_a = counters[0];
   end else begin : g_cnt_a_zero
      assign rsp_counter_a = 8'd0;
   end
   if (dbc_pkg::COUNTERS > 1) begin : g_cnt_b
      assign rsp_counter_b = counters[1];
   end else begin : g_cnt_b_zero
      assign rsp_counter_b = 8'd0;
   end
   if (dbc_pkg::COUNTERS > 2) begin : g_cnt_c
      assign rsp_counter_c = counters[2];
   end else begin : g_cnt_c_zero
      assign rsp_counter_c = 8'd0;
   end
   if (dbc_pkg::COUNTERS > 3) begin : g_cnt_d
      assign rsp_counter_d = counters[3];
   end else begin : g_cnt_d_zero
      assign rsp_counter_d = 8'd0;
   end

   // The changed flag and a sequence step always go together.
   a_seq_tracks_changed: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_changed == (rsp_sequence_number != $past(rsp_sequence_number)))
      else $error("sequence number and changed flag disagree");

   // A pending response must block the state update.
   a_no_advance_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !advance)
      else $error("state advanced while the response was stalled");

   // An empty input stage always takes a request.
   a_empty_stage_ready: assert property (@(posedge clock) disable iff (reset)
      !stage_valid_ff |-> req_ready)
      else $error("input stage empty but not ready");

   // Without an advance the previous pin image must hold.
   a_prev_pins_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(prev_pins_ff))
      else $error("previous pins changed without a processed request");

endmodule
